@@ rtl/sec_pkg.sv @@
// shared types, constants and sine table for the stereo ensemble chorus
package sec_pkg;

  localparam int VOICE_COUNT = 3;
  localparam int VIDX_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LFO_INC  = 3'd0,
    CFG_DEPTH    = 3'd1,
    CFG_LENGTH   = 3'd2,
    CFG_FEEDBACK = 3'd3,
    CFG_MIX      = 3'd4
  } cfg_reg_e;

  localparam logic [19:0] RST_LFO_INC  = 20'd175;
  localparam logic [17:0] RST_DEPTH    = 18'd768;
  localparam logic [12:0] RST_LENGTH   = 13'd4096;
  localparam logic [15:0] RST_FEEDBACK = 16'd0;
  localparam logic [16:0] RST_MIX      = 17'd32768;

  localparam int          MIN_LENGTH     = 64;
  localparam logic [15:0] FEEDBACK_LIMIT = 16'd45875;
  localparam logic [16:0] MIX_FULL       = 17'd65536;
  localparam logic [16:0] RATE_UP        = 17'd70124;
  localparam logic [16:0] RATE_DOWN      = 17'd60948;
  localparam logic [17:0] PAN_SIDE       = 18'd42598;
  localparam logic [17:0] PAN_UNITY      = 18'd65536;
  localparam logic [10:0] BASE_DISTANCE  = 11'd1024;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_FB, ST_WR, ST_INC, ST_PH, ST_SIN, ST_DEP, ST_ADR,
    ST_RD1, ST_TAP, ST_ACC, ST_DIV0, ST_DIV1, ST_DIV2, ST_MIX, ST_OUT
  } step_e;

  typedef struct packed {
    step_e             step;
    logic [VIDX_W-1:0] voice;
  } sec_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic out_free;
  } sec_status_t;

  localparam logic [15:0] QUARTER_WAVE [65] = '{
    16'd0, 16'd804, 16'd1608, 16'd2410, 16'd3212, 16'd4011, 16'd4808, 16'd5602,
    16'd6393, 16'd7179, 16'd7962, 16'd8739, 16'd9512, 16'd10278, 16'd11039,
    16'd11793, 16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446, 16'd16151,
    16'd16846, 16'd17530, 16'd18204, 16'd18868, 16'd19519, 16'd20159, 16'd20787,
    16'd21403, 16'd22005, 16'd22594, 16'd23170, 16'd23731, 16'd24279, 16'd24811,
    16'd25329, 16'd25832, 16'd26319, 16'd26790, 16'd27245, 16'd27683, 16'd28105,
    16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956, 16'd30273, 16'd30571,
    16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971, 16'd32137,
    16'd32285, 16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728, 16'd32757,
    16'd32767
  };

  function automatic logic signed [16:0] wave_point(input logic [7:0] idx);
    logic [6:0]         k;
    logic signed [16:0] v;
    k = {1'b0, idx[5:0]};
    if (idx[6]) begin
      v = $signed({1'b0, QUARTER_WAVE[7'd64 - k]});
    end else begin
      v = $signed({1'b0, QUARTER_WAVE[k]});
    end
    return idx[7] ? -v : v;
  endfunction

  function automatic logic [17:0] pan_left(input logic [VIDX_W-1:0] voice);
    return (voice == VIDX_W'(2)) ? PAN_SIDE : PAN_UNITY;
  endfunction

  function automatic logic [17:0] pan_right(input logic [VIDX_W-1:0] voice);
    return (voice == VIDX_W'(0)) ? PAN_SIDE : PAN_UNITY;
  endfunction

endpackage

@@ rtl/sec_ctrl.sv @@
// sequencer that steps the datapath through store clear, feedback write, voices and mix
module sec_ctrl import sec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sec_status_t status_i,
  output sec_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_FB, S_WR, S_INC, S_PH, S_SIN, S_DEP, S_ADR,
    S_RD1, S_TAP, S_ACC, S_DIV0, S_DIV1, S_DIV2, S_MIX, S_OUT
  } state_e;

  state_e            state_q, state_d;
  logic [VIDX_W-1:0] voice_q, voice_d;
  logic              in_ready_q;

  always_comb begin
    state_d = state_q;
    voice_d = voice_q;
    unique case (state_q)
      S_CLEAR: if (status_i.clear_done) state_d = S_IDLE;
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_FB;
          voice_d = '0;
        end
      end
      S_FB:  state_d = S_WR;
      S_WR:  state_d = S_INC;
      S_INC: state_d = S_PH;
      S_PH:  state_d = S_SIN;
      S_SIN: state_d = S_DEP;
      S_DEP: state_d = S_ADR;
      S_ADR: state_d = S_RD1;
      S_RD1: state_d = S_TAP;
      S_TAP: state_d = S_ACC;
      S_ACC: begin
        if (voice_q == VIDX_W'(VOICE_COUNT - 1)) begin
          state_d = S_DIV0;
        end else begin
          state_d = S_INC;
          voice_d = voice_q + VIDX_W'(1);
        end
      end
      S_DIV0: state_d = S_DIV1;
      S_DIV1: state_d = S_DIV2;
      S_DIV2: state_d = S_MIX;
      S_MIX:  state_d = S_OUT;
      S_OUT:  if (status_i.out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      voice_q    <= '0;
      in_ready_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      voice_q    <= voice_d;
      in_ready_q <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = in_ready_q;

  always_comb begin
    cmd_o.voice = voice_q;
    unique case (state_q)
      S_CLEAR: cmd_o.step = ST_CLEAR;
      S_IDLE:  cmd_o.step = ST_IDLE;
      S_FB:    cmd_o.step = ST_FB;
      S_WR:    cmd_o.step = ST_WR;
      S_INC:   cmd_o.step = ST_INC;
      S_PH:    cmd_o.step = ST_PH;
      S_SIN:   cmd_o.step = ST_SIN;
      S_DEP:   cmd_o.step = ST_DEP;
      S_ADR:   cmd_o.step = ST_ADR;
      S_RD1:   cmd_o.step = ST_RD1;
      S_TAP:   cmd_o.step = ST_TAP;
      S_ACC:   cmd_o.step = ST_ACC;
      S_DIV0:  cmd_o.step = ST_DIV0;
      S_DIV1:  cmd_o.step = ST_DIV1;
      S_DIV2:  cmd_o.step = ST_DIV2;
      S_MIX:   cmd_o.step = ST_MIX;
      S_OUT:   cmd_o.step = ST_OUT;
      default: cmd_o.step = ST_CLEAR;
    endcase
  end

endmodule

@@ rtl/sec_datapath.sv @@
// delay store, lfo phases, tap interpolation, voice sum and dry/wet mix
module sec_datapath import sec_pkg::*; #(
  parameter int DELAY_DEPTH = 4096,
  parameter int SAMPLE_BITS = 24,
  parameter int PHASE_BITS  = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sec_cmd_t                      cmd_i,
  output sec_status_t                   status_o,
  input  logic                          in_valid_i,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int SB    = SAMPLE_BITS;
  localparam int PB    = PHASE_BITS;
  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int LW    = AW + 1;
  localparam int INCW  = 21;
  localparam int SUMW  = ((PB > INCW) ? PB : INCW) + 1;
  localparam int DW    = 20;
  localparam int CW    = ((LW + 8) > DW) ? (LW + 8) : DW;
  localparam int ACCW  = SB + 20;
  localparam int TW    = SB + 1;
  localparam logic [TW-1:0] RECIP = TW'({TW{1'b1}} / 3);
  localparam logic signed [SB+4:0] SMAX = (SB+5)'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [SB+4:0] SMIN = -SMAX - (SB+5)'(1);

  function automatic logic signed [SB-1:0] sat(input logic signed [SB+4:0] v);
    if (v > SMAX) return SB'(SMAX);
    if (v < SMIN) return SB'(SMIN);
    return SB'(v);
  endfunction

  // configuration
  logic [19:0] lfo_q;
  logic [17:0] depth_q;
  logic [12:0] length_q;
  logic [15:0] fbg_q;
  logic [16:0] mix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfo_q    <= RST_LFO_INC;
      depth_q  <= RST_DEPTH;
      length_q <= RST_LENGTH;
      fbg_q    <= RST_FEEDBACK;
      mix_q    <= RST_MIX;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LFO_INC:  lfo_q    <= cfg_data_i[19:0];
        CFG_DEPTH:    depth_q  <= cfg_data_i[17:0];
        CFG_LENGTH:   length_q <= cfg_data_i[12:0];
        CFG_FEEDBACK: fbg_q    <= cfg_data_i[15:0];
        CFG_MIX:      mix_q    <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0] len;
  logic [15:0]   fb_cl;
  logic [16:0]   mix_cl;

  always_comb begin
    if (32'(length_q) < 32'(MIN_LENGTH)) begin
      len = LW'(MIN_LENGTH);
    end else if (32'(length_q) > 32'(DELAY_DEPTH)) begin
      len = LW'(DELAY_DEPTH);
    end else begin
      len = LW'(length_q);
    end
    fb_cl  = (fbg_q > FEEDBACK_LIMIT) ? FEEDBACK_LIMIT : fbg_q;
    mix_cl = (mix_q > MIX_FULL) ? MIX_FULL : mix_q;
  end

  // state registers
  logic [AW-1:0]             clr_q, wpos_q, wp_q, r1_q;
  logic signed [SB-1:0]      dry_l_q, dry_r_q, s0_l_q, s0_r_q;
  logic [2*SB-1:0]           rd_q;
  logic signed [SB+16:0]     fbp_l_q, fbp_r_q;
  logic [INCW-1:0]           inc_q;
  logic [PB-1:0]             phase_q [VOICE_COUNT];
  logic signed [16:0]        sa_q;
  logic signed [34:0]        sprod_q;
  logic [33:0]               dprod_q;
  logic [7:0]                f_q;
  logic signed [SB+9:0]      tp_l_q, tp_r_q;
  logic signed [ACCW-1:0]    acc_l_q, acc_r_q;
  logic [TW-1:0]             t_l_q, t_r_q;
  logic                      neg_l_q, neg_r_q;
  logic [2*TW-1:0]           qp_l_q, qp_r_q;
  logic signed [SB:0]        wet_l_q, wet_r_q;
  logic signed [SB+19:0]     mp_l_q, mp_r_q;
  logic signed [SB-1:0]      out_l_q, out_r_q;
  logic                      out_valid_q;

  logic [2*SB-1:0] mem [DELAY_DEPTH];

  // combinational helpers
  logic            accept, out_free;
  logic [AW-1:0]   wp_cur, prev_cur, r0;
  logic            mem_we;
  logic [AW-1:0]   mem_wa, mem_ra;
  logic [2*SB-1:0] mem_wd;
  logic signed [SB-1:0] rd_l, rd_r;
  logic [37:0]     incp;
  logic [16:0]     kmul;
  logic [31:0]     p32;
  logic signed [16:0] wa, wb, s_val;
  logic [15:0]     s_pos;
  logic [DW-1:0]   tap_dist;
  logic [CW-1:0]   cap, dcl;
  logic [LW-1:0]   da;
  logic [LW:0]     r0sum;
  logic signed [SB:0]    diff_l, diff_r, tl, tr;
  logic [17:0]     pl, pr;
  logic [ACCW-1:0] m_l, m_r;
  logic [TW-1:0]   est_l, est_r, q_l, q_r;
  logic [TW+1:0]   rem_l, rem_r;
  logic signed [SB:0] wv_l, wv_r;

  assign accept   = (cmd_i.step == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || out_ready_i;
  assign rd_l     = $signed(rd_q[2*SB-1:SB]);
  assign rd_r     = $signed(rd_q[SB-1:0]);

  always_comb begin
    wp_cur   = ({1'b0, wpos_q} >= len) ? '0 : wpos_q;
    prev_cur = (wp_cur == '0) ? AW'(len - LW'(1)) : wp_cur - AW'(1);

    kmul = (cmd_i.voice == VIDX_W'(1)) ? RATE_UP : RATE_DOWN;
    incp = 38'(lfo_q) * 38'(kmul) + 38'd32768;

    p32 = 32'(phase_q[cmd_i.voice]) << (32 - PB);
    wa  = wave_point(p32[31:24]);
    wb  = wave_point(p32[31:24] + 8'd1);

    s_val = sa_q + 17'(sprod_q >>> 16);
    s_pos = 16'(s_val + 17'sd32767);

    tap_dist = DW'(BASE_DISTANCE) + DW'(dprod_q >> 15);
    cap      = CW'(len - LW'(2)) << 8;
    dcl      = (CW'(tap_dist) > cap) ? cap : CW'(tap_dist);
    da       = LW'(dcl >> 8);
    r0sum    = (LW+1)'(wp_q) + (LW+1)'(len) - (LW+1)'(da);
    r0       = (r0sum >= (LW+1)'(len)) ? AW'(r0sum - (LW+1)'(len)) : AW'(r0sum);

    diff_l = (SB+1)'(rd_l) - (SB+1)'(s0_l_q);
    diff_r = (SB+1)'(rd_r) - (SB+1)'(s0_r_q);
    tl = (SB+1)'(s0_l_q) + (SB+1)'(tp_l_q >>> 8);
    tr = (SB+1)'(s0_r_q) + (SB+1)'(tp_r_q >>> 8);
    pl = pan_left(cmd_i.voice);
    pr = pan_right(cmd_i.voice);

    m_l = acc_l_q[ACCW-1] ? ACCW'(-acc_l_q) : ACCW'(acc_l_q);
    m_r = acc_r_q[ACCW-1] ? ACCW'(-acc_r_q) : ACCW'(acc_r_q);

    est_l = TW'(qp_l_q >> TW);
    est_r = TW'(qp_r_q >> TW);
    rem_l = (TW+2)'(t_l_q) - (TW+2)'(3) * (TW+2)'(est_l);
    rem_r = (TW+2)'(t_r_q) - (TW+2)'(3) * (TW+2)'(est_r);
    q_l = est_l + ((rem_l >= (TW+2)'(6)) ? TW'(2) : (rem_l >= (TW+2)'(3)) ? TW'(1) : TW'(0));
    q_r = est_r + ((rem_r >= (TW+2)'(6)) ? TW'(2) : (rem_r >= (TW+2)'(3)) ? TW'(1) : TW'(0));
    wv_l = $signed((SB+1)'(q_l));
    wv_r = $signed((SB+1)'(q_r));
  end

  // store port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = wp_q;
    mem_wd = {sat((SB+5)'(dry_l_q) + (SB+5)'(fbp_l_q >>> 16)),
              sat((SB+5)'(dry_r_q) + (SB+5)'(fbp_r_q >>> 16))};
    case (cmd_i.step)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
      end
      ST_WR: mem_we = 1'b1;
      default: ;
    endcase
    case (cmd_i.step)
      ST_ADR:  mem_ra = r0;
      ST_RD1:  mem_ra = r1_q;
      default: mem_ra = prev_cur;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      wpos_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        phase_q[i] <= '0;
      end
    end else begin
      if (cmd_i.step == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.step == ST_WR) begin
        wpos_q <= ((LW'(wp_q) + LW'(1)) >= len) ? '0 : wp_q + AW'(1);
      end
      if (cmd_i.step == ST_PH) begin
        phase_q[cmd_i.voice] <= PB'(SUMW'(phase_q[cmd_i.voice]) + SUMW'(inc_q));
      end
      if ((cmd_i.step == ST_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // arithmetic pipeline
  always_ff @(posedge clk_i) begin
    if (accept) begin
      dry_l_q <= left_in_i;
      dry_r_q <= right_in_i;
      wp_q    <= wp_cur;
      acc_l_q <= '0;
      acc_r_q <= '0;
    end
    case (cmd_i.step)
      ST_FB: begin
        fbp_l_q <= rd_l * $signed({1'b0, fb_cl});
        fbp_r_q <= rd_r * $signed({1'b0, fb_cl});
      end
      ST_INC: begin
        inc_q <= (cmd_i.voice == '0) ? INCW'(lfo_q) : INCW'(incp >> 16);
      end
      ST_SIN: begin
        sa_q    <= wa;
        sprod_q <= (18'(wb) - 18'(wa)) * $signed({1'b0, p32[23:8]});
      end
      ST_DEP: dprod_q <= 34'(depth_q) * 34'(s_pos);
      ST_ADR: begin
        f_q  <= dcl[7:0];
        r1_q <= (r0 == '0) ? AW'(len - LW'(1)) : r0 - AW'(1);
      end
      ST_RD1: begin
        s0_l_q <= rd_l;
        s0_r_q <= rd_r;
      end
      ST_TAP: begin
        tp_l_q <= diff_l * $signed({1'b0, f_q});
        tp_r_q <= diff_r * $signed({1'b0, f_q});
      end
      ST_ACC: begin
        acc_l_q <= acc_l_q + ACCW'(tl * $signed({1'b0, pl}));
        acc_r_q <= acc_r_q + ACCW'(tr * $signed({1'b0, pr}));
      end
      ST_DIV0: begin
        t_l_q   <= TW'(m_l >> 16);
        t_r_q   <= TW'(m_r >> 16);
        neg_l_q <= acc_l_q[ACCW-1];
        neg_r_q <= acc_r_q[ACCW-1];
      end
      ST_DIV1: begin
        qp_l_q <= (2*TW)'(t_l_q) * (2*TW)'(RECIP);
        qp_r_q <= (2*TW)'(t_r_q) * (2*TW)'(RECIP);
      end
      ST_DIV2: begin
        wet_l_q <= neg_l_q ? -wv_l : wv_l;
        wet_r_q <= neg_r_q ? -wv_r : wv_r;
      end
      ST_MIX: begin
        mp_l_q <= ((SB+2)'(wet_l_q) - (SB+2)'(dry_l_q)) * $signed({1'b0, mix_cl});
        mp_r_q <= ((SB+2)'(wet_r_q) - (SB+2)'(dry_r_q)) * $signed({1'b0, mix_cl});
      end
      ST_OUT: begin
        if (out_free) begin
          out_l_q <= sat((SB+5)'(dry_l_q) + (SB+5)'(mp_l_q >>> 16));
          out_r_q <= sat((SB+5)'(dry_r_q) + (SB+5)'(mp_r_q >>> 16));
        end
      end
      default: ;
    endcase
  end

  assign status_o.clear_done = (clr_q == AW'(DELAY_DEPTH - 1));
  assign status_o.out_free   = out_free;
  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

endmodule

@@ rtl/stereo_ensemble_chorus.sv @@
// three-voice stereo chorus: top level joining sequencer and datapath
// pacing: one item at a time; a new one is taken only in idle, after the last
//   result is loaded into the output register; eight steps per voice on the
//   shared tap multipliers and the single read port of the delay store set this
// reset: the delay store is zeroed one entry a cycle until all are clear,
//   during which no item is accepted; config writes are taken throughout
module stereo_ensemble_chorus import sec_pkg::*; #(
  parameter int DELAY_DEPTH = 4096,
  parameter int SAMPLE_BITS = 24,
  parameter int PHASE_BITS  = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] left_in_i,
  input  logic signed [SAMPLE_BITS-1:0] right_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i
);

  sec_cmd_t    cmd;
  sec_status_t status;

  sec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sec_datapath #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .PHASE_BITS  (PHASE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_valid_i  (in_valid_i),
    .left_in_i   (left_in_i),
    .right_in_i  (right_in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule
